// ===== sv/fcjs_pkg.sv =====
// fcjs_pkg: shared widths, codes, status struct and the arctangent table
// for the field-centric joystick shaper; depends on nothing
`timescale 1ns / 1ps

package fcjs_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 50;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // stick, trigger and heading fields
    localparam int AXIS_W    = 16;
    localparam int HEADING_W = 16;

    // shaped axis value in q5.8 before rotation
    localparam int SHAPED_W = 13;

    // rotator datapath: q8.16 vector, angle in units of pi / 2^19
    localparam int CORDIC_W     = 24;
    localparam int ANGLE_W      = 22;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_W       = 18;

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 22'sd262144;

    // rotator status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_rot_status;

    // arctangent of 2^-i in angle units
    function automatic logic [ATAN_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            4'd0:    a = 18'd131072;
            4'd1:    a = 18'd77376;
            4'd2:    a = 18'd40884;
            4'd3:    a = 18'd20753;
            4'd4:    a = 18'd10417;
            4'd5:    a = 18'd5213;
            4'd6:    a = 18'd2607;
            4'd7:    a = 18'd1304;
            4'd8:    a = 18'd652;
            4'd9:    a = 18'd326;
            4'd10:   a = 18'd163;
            4'd11:   a = 18'd81;
            4'd12:   a = 18'd41;
            4'd13:   a = 18'd20;
            4'd14:   a = 18'd10;
            4'd15:   a = 18'd5;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/fcjs_mul.sv =====
// fcjs_mul: the shared signed multiplier with a registered product
// depends on fcjs_pkg for operand widths
`timescale 1ns / 1ps

module fcjs_mul (
    input  logic                                 i_clk,
    input  logic signed [fcjs_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [fcjs_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [fcjs_pkg::PROD_W-1:0]   o_prod
);
    import fcjs_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/fcjs_cordic.sv =====
// fcjs_cordic: iterative vector rotator, quarter-turn pre-rotation then
// one micro-rotation per cycle through two variable shifters; depends on fcjs_pkg
`timescale 1ns / 1ps

module fcjs_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [fcjs_pkg::SHAPED_W-1:0]   i_px,
    input  logic signed [fcjs_pkg::SHAPED_W-1:0]   i_py,
    input  logic signed [fcjs_pkg::HEADING_W-1:0]  i_heading,
    output fcjs_pkg::t_rot_status                  o_status,
    output logic signed [fcjs_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [fcjs_pkg::CORDIC_W-1:0]   o_y
);
    import fcjs_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, n_x;
    logic signed [CORDIC_W-1:0] r_y, n_y;
    logic signed [ANGLE_W-1:0]  r_z, n_z;
    logic [ITER_W-1:0]          r_iter, n_iter;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    logic signed [CORDIC_W-1:0] w_x0, w_y0;
    logic signed [ANGLE_W-1:0]  w_z0;
    logic signed [CORDIC_W-1:0] w_dx, w_dy;
    logic signed [ANGLE_W-1:0]  w_atan;

    always_comb begin
        // q5.8 to q8.16, binary radians to pi / 2^19
        w_x0   = CORDIC_W'($signed({i_px, 8'd0}));
        w_y0   = CORDIC_W'($signed({i_py, 8'd0}));
        w_z0   = ANGLE_W'($signed({i_heading, 4'd0}));
        w_dx   = r_y >>> r_iter;
        w_dy   = r_x >>> r_iter;
        w_atan = $signed(ANGLE_W'(atan_step(r_iter)));

        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_iter = r_iter;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_start) begin
            n_iter = '0;
            n_busy = 1'b1;
            priority if (w_z0 > QUARTER_TURN) begin
                n_x = -w_y0;
                n_y = w_x0;
                n_z = w_z0 - QUARTER_TURN;
            end else if (w_z0 < -QUARTER_TURN) begin
                n_x = w_y0;
                n_y = -w_x0;
                n_z = w_z0 + QUARTER_TURN;
            end else begin
                n_x = w_x0;
                n_y = w_y0;
                n_z = w_z0;
            end
        end else if (r_busy) begin
            if (!r_z[ANGLE_W-1]) begin
                n_x = r_x - w_dx;
                n_y = r_y + w_dy;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_dx;
                n_y = r_y - w_dy;
                n_z = r_z + w_atan;
            end
            n_iter = r_iter + 1'b1;
            if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_x           = r_x;
    assign o_y           = r_y;

endmodule

// ===== sv/field_centric_joystick_shaper.sv =====
// field_centric_joystick_shaper: top level, sequencer, config registers
// and output register; uses fcjs_pkg, fcjs_mul and fcjs_cordic
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one joystick sample per transfer
// m_axis    out  m_axis_tvalid / m_axis_tready  one command per sample
// cfg       in   i_cfg_valid / o_cfg_ready      register index and write data
//
// one sample runs through 16 shared-multiplier steps for the axis cubes,
// trigger powers and turn scale, then the rotator's micro-rotation loop,
// then 3 multiplier steps for the gain correction, then one output
// load. a sample that ends in a brake or an idle result skips the rotator.
// s_axis_tready is high only in idle; a pending result in the output register
// does not block the next sample, only the load of the following result.
// reset is synchronous, active low, and restores the register defaults.
`timescale 1ns / 1ps

module field_centric_joystick_shaper (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // [15:0] stick_x, [31:16] stick_y, [47:32] trigger_left,
    // [63:48] trigger_right, [79:64] heading
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,

    // [13:0] vel_forward, [27:14] vel_side, [40:28] turn_rate, [47:41] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    // [1:0] action
    output logic [1:0]  m_axis_tuser,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import fcjs_pkg::*;

    // result kinds
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_BRAKE    = 2'd1;
    localparam logic [1:0] ACT_VELOCITY = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_DZ_LEVEL  = 2'd0;
    localparam logic [1:0] CFG_LIN_SPEED = 2'd1;
    localparam logic [1:0] CFG_TURN_RATE = 2'd2;

    localparam logic signed [MUL_B_W-1:0] INV_GAIN = 18'sd39797;

    localparam int VEL_W  = 14;
    localparam int TURN_W = 13;
    localparam int U_W    = 20;
    localparam int POW_W  = 33;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ARITH = 5'b00010,
        S_ROT   = 5'b00100,
        S_SCALE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // round to nearest, halves away from zero, by an arithmetic shift
    function automatic logic signed [PROD_W-1:0] round_away(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sum;
        half       = '0;
        half[sh-1] = 1'b1;
        sum        = v + half - $signed(PROD_W'(v[PROD_W-1]));
        return sum >>> sh;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [U_W:0] v);
        logic signed [VEL_W-1:0] r;
        priority if (v > (U_W+1)'(8191)) begin
            r = 14'sd8191;
        end else if (v < -(U_W+1)'(8192)) begin
            r = -14'sd8192;
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TURN_W-1:0] sat_turn(input logic signed [15:0] v);
        logic signed [TURN_W-1:0] r;
        priority if (v > 16'sd4095) begin
            r = 13'sd4095;
        end else if (v < -16'sd4096) begin
            r = -13'sd4096;
        end else begin
            r = v[TURN_W-1:0];
        end
        return r;
    endfunction

    // config registers
    logic [14:0] r_dz_level;
    logic [11:0] r_lin_speed;
    logic [11:0] r_turn_max;

    // sequencer
    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic        r_brake_sent;
    logic        r_zero;

    // latched sample and intermediates
    logic signed [AXIS_W-1:0]    r_sx, r_sy;
    logic [AXIS_W-1:0]           r_tl, r_tr;
    logic signed [HEADING_W-1:0] r_heading;
    logic signed [SHAPED_W-1:0]  r_side, r_fwd;
    logic [POW_W-1:0]            r_pl, r_pr;
    logic signed [TURN_W-1:0]    r_turn;
    logic signed [U_W-1:0]       r_u0, r_u1;

    // output register
    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic [1:0]  r_m_user;

    // shared multiplier and rotator hookup
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_r45, w_r32, w_r24;
    logic signed [33:0]         w_pdiff;
    logic                       w_rot_start;
    t_rot_status                w_rot_status;
    logic signed [CORDIC_W-1:0] w_rot_x, w_rot_y;

    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_load;
    logic [16:0] w_ax, w_ay;
    logic        w_in_dz;
    logic signed [VEL_W-1:0]  w_vel_fwd, w_vel_side;
    logic signed [TURN_W-1:0] w_turn_out;
    logic [1:0]               w_action;

    fcjs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    fcjs_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rot_start),
        .i_px      (r_fwd),
        .i_py      (r_side),
        .i_heading (r_heading),
        .o_status  (w_rot_status),
        .o_x       (w_rot_x),
        .o_y       (w_rot_y)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = r_m_valid && m_axis_tready;

    // result can load once the output register is empty or being drained
    assign w_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    // dead zone: both magnitudes must be inside, -32768 counts as 32768
    always_comb begin
        w_ax    = s_axis_tdata[15] ? 17'(-$signed({1'b1, s_axis_tdata[15:0]}))
                                   : {1'b0, s_axis_tdata[15:0]};
        w_ay    = s_axis_tdata[31] ? 17'(-$signed({1'b1, s_axis_tdata[31:16]}))
                                   : {1'b0, s_axis_tdata[31:16]};
        w_in_dz = (w_ax <= {2'b00, r_dz_level}) && (w_ay <= {2'b00, r_dz_level});
    end

    // rounding taps on the registered product
    assign w_r45   = round_away(w_prod, 45);
    assign w_r32   = round_away(w_prod, 32);
    assign w_r24   = round_away(w_prod, 24);
    assign w_pdiff = $signed({1'b0, r_pl}) - $signed({1'b0, r_pr});

    // multiplier operand schedule; each product is read one step later
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_ARITH) begin
            unique case (r_step)
                4'd0: begin
                    w_mul_a = MUL_A_W'(r_sx);
                    w_mul_b = MUL_B_W'(r_sx);
                end
                4'd1, 4'd4: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'($signed({1'b0, r_lin_speed}));
                end
                4'd2: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'(r_sx);
                end
                4'd3: begin
                    w_mul_a = MUL_A_W'(r_sy);
                    w_mul_b = MUL_B_W'(r_sy);
                end
                4'd5: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'(r_sy);
                end
                4'd6: begin
                    w_mul_a = MUL_A_W'($signed({1'b0, r_tl}));
                    w_mul_b = MUL_B_W'($signed({1'b0, r_tl}));
                end
                4'd7, 4'd8: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'($signed({1'b0, r_tl}));
                end
                4'd9: begin
                    w_mul_a = MUL_A_W'($signed({1'b0, r_tr}));
                    w_mul_b = MUL_B_W'($signed({1'b0, r_tr}));
                end
                4'd10, 4'd11: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'($signed({1'b0, r_tr}));
                end
                4'd13: begin
                    w_mul_a = MUL_A_W'(w_pdiff);
                    w_mul_b = MUL_B_W'($signed({1'b0, r_turn_max}));
                end
                default: begin
                    w_mul_a = '0;
                    w_mul_b = '0;
                end
            endcase
        end else if (r_state == S_SCALE) begin
            // gain correction, x first then y
            w_mul_a = (r_step == 4'd0) ? MUL_A_W'(w_rot_x) : MUL_A_W'(w_rot_y);
            w_mul_b = INV_GAIN;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        w_rot_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_in_xfer) begin
                    n_state = S_ARITH;
                end
            end
            S_ARITH: begin
                n_step = r_step + 1'b1;
                if (r_step == 4'd15) begin
                    n_step = '0;
                    if (r_side == '0 && r_fwd == '0 && r_turn == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state     = S_ROT;
                        w_rot_start = 1'b1;
                    end
                end
            end
            S_ROT: begin
                if (w_rot_status.done) begin
                    n_state = S_SCALE;
                    n_step  = '0;
                end
            end
            S_SCALE: begin
                n_step = r_step + 1'b1;
                if (r_step == 4'd2) begin
                    n_state = S_OUT;
                    n_step  = '0;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // result fields for the output register
    always_comb begin
        if (r_zero) begin
            w_action   = r_brake_sent ? ACT_NONE : ACT_BRAKE;
            w_vel_fwd  = '0;
            w_vel_side = '0;
            w_turn_out = '0;
        end else begin
            w_action   = ACT_VELOCITY;
            w_vel_side = sat_vel((U_W+1)'(r_u0));
            w_vel_fwd  = sat_vel(-((U_W+1)'(r_u1)));
            w_turn_out = r_turn;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_brake_sent <= 1'b0;
            r_m_valid    <= 1'b0;
            r_dz_level   <= 15'd6554;
            r_lin_speed  <= 12'd922;
            r_turn_max   <= 12'd2253;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_load) begin
                r_m_valid    <= 1'b1;
                r_brake_sent <= r_zero;
            end else if (w_out_xfer) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DZ_LEVEL:  r_dz_level  <= i_cfg_data[14:0];
                    CFG_LIN_SPEED: r_lin_speed <= i_cfg_data[11:0];
                    CFG_TURN_RATE: r_turn_max  <= i_cfg_data[11:0];
                    default: begin
                        // unknown index, write dropped
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            // both axes zeroed together inside the dead zone
            r_sx      <= w_in_dz ? '0 : $signed(s_axis_tdata[15:0]);
            r_sy      <= w_in_dz ? '0 : $signed(s_axis_tdata[31:16]);
            r_tl      <= s_axis_tdata[47:32];
            r_tr      <= s_axis_tdata[63:48];
            r_heading <= $signed(s_axis_tdata[79:64]);
        end
        if (r_state == S_ARITH) begin
            unique case (r_step)
                4'd3:  r_side <= w_r45[SHAPED_W-1:0];
                4'd6:  r_fwd  <= w_r45[SHAPED_W-1:0];
                4'd9:  r_pl   <= w_r32[POW_W-1:0];
                4'd12: r_pr   <= w_r32[POW_W-1:0];
                4'd14: r_turn <= sat_turn(w_r32[15:0]);
                4'd15: r_zero <= (r_side == '0 && r_fwd == '0 && r_turn == '0);
                default: begin
                    // operand issue only
                end
            endcase
        end
        if (r_state == S_SCALE) begin
            if (r_step == 4'd1) begin
                r_u0 <= w_r24[U_W-1:0];
            end
            if (r_step == 4'd2) begin
                r_u1 <= w_r24[U_W-1:0];
            end
        end
        if (w_load) begin
            r_m_data <= {7'd0, w_turn_out, w_vel_side, w_vel_fwd};
            r_m_user <= w_action;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== verif/fcjs_tb_pkg.sv =====
// fcjs_tb_pkg: bench-side types for the joystick shaper, sample and command
// layouts as they sit on the streams plus register and action codes; depends on nothing
`timescale 1ns / 1ps

package fcjs_tb_pkg;

    typedef enum logic [1:0] {
        REG_DZ_LEVEL     = 2'd0,
        REG_LINEAR_SPEED = 2'd1,
        REG_TURN_SCALE   = 2'd2,
        REG_SPARE        = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_BRAKE = 2'd1,
        ACT_DRIVE = 2'd2
    } t_action;

    // stick_x sits in the lowest bits of the input tdata
    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] trigger_right;
        logic [15:0] trigger_left;
        logic [15:0] stick_y;
        logic [15:0] stick_x;
    } t_joy;

    // vel_forward sits in the lowest bits of the output tdata
    typedef struct packed {
        logic [6:0]  spare;
        logic [12:0] turn_rate;
        logic [13:0] vel_side;
        logic [13:0] vel_forward;
    } t_cmd_data;

    typedef struct packed {
        t_action   action;
        t_cmd_data data;
    } t_cmd;

    localparam int DZ_LEVEL_RESET     = 6554;
    localparam int LINEAR_SPEED_RESET = 922;
    localparam int TURN_SCALE_RESET   = 2253;

endpackage

// ===== verif/fcjs_command_check.sv =====
// fcjs_command_check: watches the sample, command and register channels of the
// joystick shaper, predicts every command and compares; uses fcjs_tb_pkg
`timescale 1ns / 1ps

module fcjs_command_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_joy_valid,
    input  logic        i_joy_ready,
    input  logic [79:0] i_joy_data,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [47:0] i_cmd_data,
    input  logic [1:0]  i_cmd_action,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_brakes,
    output int          o_holds,
    output int          o_drives
);
    import fcjs_tb_pkg::*;

    localparam longint QUARTER  = 262144;
    localparam longint INV_GAIN = 39797;
    localparam longint ARCTAN [0:15] = '{
        131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
        652, 326, 163, 81, 41, 20, 10, 5
    };

    longint dz_level     = longint'(DZ_LEVEL_RESET);
    longint linear_speed = longint'(LINEAR_SPEED_RESET);
    longint turn_scale   = longint'(TURN_SCALE_RESET);
    logic   brake_latched = 1'b0;
    t_cmd   expected_cmds [$];
    int     mismatch_count = 0;
    int     brake_count = 0;
    int     hold_count = 0;
    int     drive_count = 0;

    function automatic longint round_half_away(input longint v, input int sh);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // t^4 in q0.32
    function automatic longint trigger_power(input logic [15:0] t);
        longint unsigned tw;
        longint unsigned sq;
        longint unsigned quad;
        tw = 64'(t);
        sq = tw * tw;
        quad = sq * sq;
        return longint'(((quad >> 31) + 1) >> 1);
    endfunction

    // 16-step cordic in q8.16, angle unit pi / 2^19
    function automatic void rotate_to_field(input longint fwd, input longint side,
                                            input longint head,
                                            output longint u0, output longint u1);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint swap;
        x = fwd * 256;
        y = side * 256;
        z = head * 16;
        if (z > QUARTER) begin
            swap = x;
            x = -y;
            y = swap;
            z -= QUARTER;
        end else if (z < -QUARTER) begin
            swap = x;
            x = y;
            y = -swap;
            z += QUARTER;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN[i];
            end
        end
        u0 = round_half_away(x * INV_GAIN, 24);
        u1 = round_half_away(y * INV_GAIN, 24);
    endfunction

    // expected command for one sample; advances the brake latch
    function automatic t_cmd shape_joy(input t_joy j);
        longint sx;
        longint sy;
        longint side;
        longint fwd;
        longint turn;
        longint u0;
        longint u1;
        longint vs;
        longint vf;
        t_cmd   c;
        sx = longint'($signed(j.stick_x));
        sy = longint'($signed(j.stick_y));
        if (((sx < 0) ? -sx : sx) <= dz_level && ((sy < 0) ? -sy : sy) <= dz_level) begin
            sx = 0;
            sy = 0;
        end
        side = round_half_away(sx * sx * sx * linear_speed, 45);
        fwd  = round_half_away(sy * sy * sy * linear_speed, 45);
        turn = round_half_away((trigger_power(j.trigger_left)
                                - trigger_power(j.trigger_right)) * turn_scale, 32);
        turn = clamp(turn, -4096, 4095);
        c = '0;
        if (side == 0 && fwd == 0 && turn == 0) begin
            c.action = brake_latched ? ACT_NONE : ACT_BRAKE;
            brake_latched = 1'b1;
        end else begin
            rotate_to_field(fwd, side, longint'($signed(j.heading)), u0, u1);
            vs = clamp(u0, -8192, 8191);
            vf = clamp(-u1, -8192, 8191);
            c.action = ACT_DRIVE;
            c.data.vel_side = vs[13:0];
            c.data.vel_forward = vf[13:0];
            brake_latched = 1'b0;
        end
        c.data.turn_rate = turn[12:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_cmd      want;
        t_cmd_data got;
        if (!i_rst_n) begin
            dz_level = longint'(DZ_LEVEL_RESET);
            linear_speed = longint'(LINEAR_SPEED_RESET);
            turn_scale = longint'(TURN_SCALE_RESET);
            brake_latched = 1'b0;
            expected_cmds.delete();
        end else begin
            // command first: its expectation is always older than a sample taken now
            if (i_cmd_valid && i_cmd_ready) begin
                got = i_cmd_data;
                if (expected_cmds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected command: act=%0d fwd=%0d side=%0d turn=%0d",
                                 i_cmd_action, $signed(got.vel_forward),
                                 $signed(got.vel_side), $signed(got.turn_rate));
                end else begin
                    want = expected_cmds.pop_front();
                    if (want.action != i_cmd_action
                        || want.data.vel_forward != got.vel_forward
                        || want.data.vel_side != got.vel_side
                        || want.data.turn_rate != got.turn_rate) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"command mismatch: expected act=%0d fwd=%0d side=%0d",
                                      " turn=%0d, got act=%0d fwd=%0d side=%0d turn=%0d"},
                                     want.action, $signed(want.data.vel_forward),
                                     $signed(want.data.vel_side),
                                     $signed(want.data.turn_rate), i_cmd_action,
                                     $signed(got.vel_forward), $signed(got.vel_side),
                                     $signed(got.turn_rate));
                    end
                    case (want.action)
                        ACT_BRAKE: brake_count++;
                        ACT_NONE:  hold_count++;
                        default:   drive_count++;
                    endcase
                end
            end
            if (i_joy_valid && i_joy_ready)
                expected_cmds.push_back(shape_joy(i_joy_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DZ_LEVEL:     dz_level = longint'(i_cfg_data[14:0]);
                    REG_LINEAR_SPEED: linear_speed = longint'(i_cfg_data[11:0]);
                    REG_TURN_SCALE:   turn_scale = longint'(i_cfg_data[11:0]);
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= expected_cmds.size();
        o_brakes <= brake_count;
        o_holds <= hold_count;
        o_drives <= drive_count;
    end

endmodule

// ===== verif/testbench.sv =====
// testbench: stimulus and verdict for field_centric_joystick_shaper; the
// checking lives in fcjs_command_check, types and codes in fcjs_tb_pkg
`timescale 1ns / 1ps

module testbench;
    import fcjs_tb_pkg::*;

    // sized for the slowest legal run: roughly 1000 samples, each with the block's
    // own processing plus long sender gaps and receiver stalls
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_ITEMS    = 190;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;    // stick_x, stick_y, trigger_left, trigger_right, heading
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // vel_forward, vel_side, turn_rate, zero fill
    logic [1:0]  m_axis_tuser;         // action
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int mismatches;
    int pending;
    int brakes;
    int holds;
    int drives;

    // stimulus knobs; stall_pct and squeeze_req are read by the receiver process
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic squeeze_req = 1'b0;
    int   dz_now = DZ_LEVEL_RESET;
    int   joys_sent = 0;
    int   cycles = 0;

    // receiver-owned hold-off state
    int   squeeze_left = 0;
    logic squeeze_done = 1'b0;

    always #1 i_clk = ~i_clk;

    field_centric_joystick_shaper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fcjs_command_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_joy_valid  (s_axis_tvalid),
        .i_joy_ready  (s_axis_tready),
        .i_joy_data   (s_axis_tdata),
        .i_cmd_valid  (m_axis_tvalid),
        .i_cmd_ready  (m_axis_tready),
        .i_cmd_data   (m_axis_tdata),
        .i_cmd_action (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_brakes     (brakes),
        .o_holds      (holds),
        .o_drives     (drives)
    );

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // command receiver: random stalls, plus one long hold-off when asked so the
    // block fills its output register and then blocks the sample stream
    always @(posedge i_clk) begin
        if (squeeze_left > 0) begin
            m_axis_tready <= 1'b0;
            squeeze_left--;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_left = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one sample transfer, with random idle cycles ahead of it; valid stays up
    // afterwards so back-to-back samples never drop it within one step
    task automatic offer_joy(input t_joy j);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= j;
        do @(posedge i_clk); while (!s_axis_tready);
        joys_sent++;
    endtask

    task automatic put(input logic [15:0] x, input logic [15:0] y, input logic [15:0] tl,
                       input logic [15:0] tr, input logic [15:0] h);
        t_joy j;
        j.stick_x = x;
        j.stick_y = y;
        j.trigger_left = tl;
        j.trigger_right = tr;
        j.heading = h;
        offer_joy(j);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // only called once the block is drained; unused upper data bits get noise
    task automatic apply_settings(input int dz, input int spd, input int trn);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(REG_DZ_LEVEL, {noise[15], dz[14:0]});
        write_reg(REG_LINEAR_SPEED, {noise[15:12], spd[11:0]});
        write_reg(REG_TURN_SCALE, {noise[11:8], trn[11:0]});
        // spare index, must leave every register alone
        write_reg(REG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
        dz_now = dz;
    endtask

    // pending is registered in the checker, so let it update after the last transfer before looking
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] edge_stick();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h8001;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return 16'hffff;
            6:       return 16'(dz_now);
            7:       return 16'(-dz_now);
            8:       return 16'(dz_now + 1);
            default: return 16'(-(dz_now + 1));
        endcase
    endfunction

    function automatic logic [15:0] edge_trigger();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h0001;
            3:       return 16'($urandom_range(4000));
            default: return 16'($urandom);
        endcase
    endfunction

    // stick inside the dead zone and light triggers: mostly zero commands
    function automatic t_joy quiet_joy();
        t_joy j;
        j.stick_x = 16'(int'($urandom_range(2 * dz_now)) - dz_now);
        j.stick_y = 16'(int'($urandom_range(2 * dz_now)) - dz_now);
        j.trigger_left = 16'($urandom_range(4000));
        j.trigger_right = ($urandom_range(1) == 1) ? j.trigger_left
                                                   : 16'($urandom_range(4000));
        j.heading = 16'($urandom);
        return j;
    endfunction

    function automatic t_joy random_joy();
        t_joy j;
        int   kind;
        kind = $urandom_range(99);
        j.trigger_left = 16'($urandom);
        j.trigger_right = 16'($urandom);
        j.heading = 16'($urandom);
        j.stick_x = 16'($urandom);
        j.stick_y = 16'($urandom);
        if (kind < 20) begin
            j.stick_x = edge_stick();
            j.stick_y = edge_stick();
            j.trigger_left = edge_trigger();
            j.trigger_right = edge_trigger();
        end else if (kind < 35) begin
            // one axis inside the dead zone, the other anywhere
            j.stick_x = 16'(int'($urandom_range(2 * dz_now)) - dz_now);
        end else if (kind < 45) begin
            j.stick_y = 16'(int'($urandom_range(2 * dz_now)) - dz_now);
        end
        return j;
    endfunction

    task automatic run_phase(input int dz, input int spd, input int trn, input int send_pct,
                             input int stall, input logic squeeze, input int count);
        int sent;
        int burst;
        wait_drained();
        apply_settings(dz, spd, trn);
        send_idle_pct = send_pct;
        stall_pct <= stall;
        squeeze_req <= squeeze;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 30) begin
                // run of zero samples: one brake, then nothing
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    offer_joy(quiet_joy());
                    sent++;
                end
            end else begin
                offer_joy(random_joy());
                sent++;
            end
        end
        squeeze_req <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples at the reset register values, no idling
        put(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);   // first zero: brake
        put(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);   // zero run continues
        put(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
        put(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff);
        put(16'd6554, -16'sd6554, 16'h0000, 16'h0000, 16'h1234);  // both at threshold
        put(16'd6555, 16'h0000, 16'h0000, 16'h0000, 16'h0000);    // just past threshold
        put(-16'sd6554, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);  // only y outside
        put(16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000);    // full left turn
        put(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);    // full right turn
        put(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0000);    // triggers cancel: brake
        put(16'h0000, 16'h0000, 16'd3000, 16'h0000, 16'h0000);    // turn rounds to zero
        put(16'd20000, -16'sd20000, 16'h0000, 16'h0000, 16'd16384);  // quarter-turn edges
        put(16'd20000, -16'sd20000, 16'h0000, 16'h0000, 16'd16385);
        put(16'd20000, -16'sd20000, 16'h0000, 16'h0000, -16'sd16384);
        put(16'd20000, -16'sd20000, 16'h0000, 16'h0000, -16'sd16385);
        put(16'h8000, 16'h8000, 16'hffff, 16'h0000, 16'h8000);
        put(16'h7fff, 16'h7fff, 16'h0000, 16'hffff, 16'h2000);
        put(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555);
        put(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'haaaa);

        // widest dead-zone-free setting at full scale, sender mostly idle
        run_phase(0, 4095, 4095, 88, 0, 1'b0, PHASE_ITEMS);
        // all but -32768 dead-zoned and scales at zero: only brake and nothing
        run_phase(32767, 0, 0, 0, 88, 1'b0, PHASE_ITEMS);
        // random setting, both sides idling now and then
        run_phase($urandom_range(32767), $urandom_range(4095), $urandom_range(4095),
                  23, 23, 1'b0, PHASE_ITEMS);
        // back to reset values under a long output hold-off
        run_phase(DZ_LEVEL_RESET, LINEAR_SPEED_RESET, TURN_SCALE_RESET, 0, 0, 1'b1,
                  PHASE_ITEMS);
        // smallest nonzero scales
        run_phase(1, 1, 1, 23, 88, 1'b0, PHASE_ITEMS);
        wait_drained();

        $display("covered %0d samples over six stimulus phases, with a long output hold-off",
                 joys_sent);
        $display("commands checked: %0d brake, %0d idle, %0d velocity", brakes, holds, drives);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fcjs_pkg.sv
sv/fcjs_mul.sv
sv/fcjs_cordic.sv
sv/field_centric_joystick_shaper.sv
verif/fcjs_tb_pkg.sv
verif/fcjs_command_check.sv
verif/testbench.sv
